[rtl/sgtd_pkg.sv]
// ----------------------------------------------------------------------------
// sgtd_pkg
// Shared types, widths and constants of the sliding Goertzel tone detector.
// ----------------------------------------------------------------------------
package sgtd_pkg;

	localparam int MAX_WINDOW_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 16;

	// configuration port
	localparam int CFG_W     = 19;
	localparam int CFG_IDX_W = 2;
	localparam int WL_CFG_W  = 9;
	localparam int COEF_W    = 19;
	localparam int CMAG_W    = 19;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LENGTH = 2'd0,
		REG_TARGET_COEF   = 2'd1,
		REG_LOWER_COEF    = 2'd2,
		REG_UPPER_COEF    = 2'd3
	} cfg_reg_t;

	localparam logic signed [COEF_W-1:0] COEF_RESET = 19'sd131072;

	// recurrence arithmetic
	localparam int FRAC_W  = 16;
	localparam int S_W     = 48;
	localparam int HI_W    = S_W - FRAC_W + CMAG_W;  // 51
	localparam int LO_W    = FRAC_W + CMAG_W;        // 35
	localparam int M_W     = 52;
	localparam int R_W     = M_W + 1;
	localparam int SUM_W   = R_W + 2;
	localparam logic [LO_W:0] ROUND_HALF = (LO_W+1)'(32768);

	// wide product unit
	localparam int DIG_W   = 16;
	localparam int MUL_DIG = S_W / DIG_W;
	localparam int PROD_W  = R_W + S_W;
	localparam int ACC_W   = PROD_W + 3;

	// results
	localparam int P_W     = 48;
	localparam int E_W     = 39;
	localparam int Q_W     = 32;
	localparam int K_W     = 18;
	localparam logic [K_W-1:0] SCORE_K = 18'd256000;
	localparam int SCN_W   = P_W + K_W;
	localparam int DEN_W   = P_W + 1;
	localparam int OUT_DATA_W = 200;

	typedef enum logic [1:0] {
		TERM_S1SQ  = 2'd0,
		TERM_S2SQ  = 2'd1,
		TERM_CROSS = 2'd2
	} term_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOD,
		ST_RUN,
		ST_FIN,
		ST_FIN2,
		ST_PWR_GO,
		ST_PWR_WAIT,
		ST_SMUL,
		ST_SDIV_GO,
		ST_SDIV_WAIT,
		ST_CDIV_GO,
		ST_CDIV_WAIT,
		ST_OUT
	} back_state_t;

	// head of the item queue as seen by the back end
	typedef struct packed {
		logic valid;
		logic clear;
	} q_ctl_t;

endpackage

[rtl/sliding_goertzel_tone_detector.sv]
// ----------------------------------------------------------------------------
// sliding_goertzel_tone_detector
// Sliding-window Goertzel detector: target and neighbour bin powers, energy,
// score and contrast for each input transfer.
//
// channel   dir  tdata                                          tuser
// s_axis    in   sample_value                                   command
// m_axis    out  score, contrast, target, neighbour, energy     window_ready
// cfg       in   write enable, index, data (no read-back)
//
// A push with a full window runs the recurrence loop over the window,
// then 9 wide products and two divisions, each division ending early
// when its quotient saturates. Clear and partial-window pushes skip
// the window pass. After a window shrink, the first push reduces the
// write position by repeated subtraction of the window length.
// Reset clears the ring valid bits at once.
// Input transfers are queued two deep while a result waits on m_axis.
// ----------------------------------------------------------------------------
module sliding_goertzel_tone_detector import sgtd_pkg::*; #(
	parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int IN_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // sample_value
	input  logic                  s_axis_tuser,   // command
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // band_score, band_contrast,
	                                              // target_power, neighbor_power,
	                                              // window_energy
	output logic                  m_axis_tuser,   // window_ready
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_wdata
);

	localparam int WL_W = $clog2(MAX_WINDOW + 1);

	logic [WL_W-1:0]          wl_q;
	logic [2:0][COEF_W-1:0]   coef_q;
	logic [WL_CFG_W-1:0]      wl_in;

	q_ctl_t                 q_ctl;
	logic [SAMPLE_BITS-1:0] q_sample;
	logic                   pop;

	logic            res_flag;
	logic [Q_W-1:0]  res_score, res_contrast;
	logic [P_W-1:0]  res_power, res_neighbor;
	logic [E_W-1:0]  res_energy;

	assign wl_in = cfg_wdata[WL_CFG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q   <= WL_W'(MAX_WINDOW);
			coef_q <= {3{COEF_RESET}};
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WINDOW_LENGTH: begin
					// zero becomes one, above the ring depth clamps to it
					if (wl_in == '0) begin
						wl_q <= WL_W'(1);
					end else if (32'(wl_in) > 32'(MAX_WINDOW)) begin
						wl_q <= WL_W'(MAX_WINDOW);
					end else begin
						wl_q <= WL_W'(wl_in);
					end
				end
				REG_TARGET_COEF: coef_q[0] <= cfg_wdata[COEF_W-1:0];
				REG_LOWER_COEF:  coef_q[1] <= cfg_wdata[COEF_W-1:0];
				REG_UPPER_COEF:  coef_q[2] <= cfg_wdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	sgtd_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_command (s_axis_tuser),
		.in_sample  (s_axis_tdata[SAMPLE_BITS-1:0]),
		.q_ctl      (q_ctl),
		.q_sample   (q_sample),
		.pop        (pop)
	);

	sgtd_back #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_ctl            (q_ctl),
		.q_sample         (q_sample),
		.pop              (pop),
		.wl               (wl_q),
		.coefs            (coef_q),
		.out_valid        (m_axis_tvalid),
		.out_ready        (m_axis_tready),
		.out_window_ready (res_flag),
		.out_score        (res_score),
		.out_contrast     (res_contrast),
		.out_power        (res_power),
		.out_neighbor     (res_neighbor),
		.out_energy       (res_energy)
	);

	assign m_axis_tuser = res_flag;
	assign m_axis_tdata = {1'b0, res_energy, res_neighbor, res_power, res_contrast, res_score};

endmodule

[rtl/sgtd_front.sv]
// ----------------------------------------------------------------------------
// sgtd_front
// Input side: takes stream transfers, splits clear from push and holds them
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module sgtd_front import sgtd_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   in_command,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	output q_ctl_t                 q_ctl,
	output logic [SAMPLE_BITS-1:0] q_sample,
	input  logic                   pop
);

	logic [SAMPLE_BITS-1:0] smp_q [2];
	logic [1:0]             clr_q;
	logic                   wr_q;
	logic                   rd_q;
	logic [1:0]             cnt_q;
	logic                   push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;

	assign q_ctl.valid = (cnt_q != 2'd0);
	assign q_ctl.clear = clr_q[rd_q];
	assign q_sample    = smp_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			smp_q[wr_q] <= in_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				clr_q[wr_q] <= in_command;
				wr_q        <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

[rtl/sgtd_wmul.sv]
// ----------------------------------------------------------------------------
// sgtd_wmul
// Signed wide multiplier, one 16-bit digit of the second operand per cycle.
// ----------------------------------------------------------------------------
module sgtd_wmul import sgtd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [R_W-1:0]   a,
	input  logic signed [S_W-1:0]   b,
	output logic                    done,
	output logic signed [ACC_W-1:0] prod
);

	logic [R_W-1:0]          am_q;
	logic [S_W-1:0]          b_q;
	logic                    neg_q;
	logic [1:0]              iss_q;
	logic [1:0]              acc_cnt_q;
	logic                    pv_s1;
	logic [R_W+DIG_W-1:0]    pp_s1;
	logic [PROD_W-1:0]       acc_q;
	logic                    done_q;
	logic                    busy_q;

	always_ff @(posedge clk) begin
		if (start) begin
			am_q  <= a[R_W-1] ? R_W'(-a) : R_W'(a);
			b_q   <= b[S_W-1] ? S_W'(-b) : S_W'(b);
			neg_q <= a[R_W-1] ^ b[S_W-1];
		end else if (busy_q && iss_q != 2'(MUL_DIG)) begin
			b_q <= b_q << DIG_W;
		end
		if (busy_q && iss_q != 2'(MUL_DIG)) begin
			pp_s1 <= am_q * b_q[S_W-1 -: DIG_W];
		end
		if (start) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			// most significant digit first
			acc_q <= (acc_q << DIG_W) + PROD_W'(pp_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			iss_q     <= '0;
			acc_cnt_q <= '0;
			pv_s1     <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			pv_s1  <= busy_q && iss_q != 2'(MUL_DIG);
			if (start) begin
				busy_q    <= 1'b1;
				iss_q     <= '0;
				acc_cnt_q <= '0;
			end else if (busy_q) begin
				if (iss_q != 2'(MUL_DIG)) begin
					iss_q <= iss_q + 2'd1;
				end
				if (pv_s1) begin
					acc_cnt_q <= acc_cnt_q + 2'd1;
					if (acc_cnt_q == 2'(MUL_DIG - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	assign done = done_q;
	assign prod = neg_q ? -$signed(ACC_W'(acc_q)) : $signed(ACC_W'(acc_q));

endmodule

[rtl/sgtd_div.sv]
// ----------------------------------------------------------------------------
// sgtd_div
// Restoring divider, one quotient bit per cycle, quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
module sgtd_div import sgtd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SCN_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [Q_W-1:0]   quo
);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [Q_W-1:0]   low_q;
	logic [Q_W-1:0]   quo_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem2;
	logic             over;

	assign rem2 = {rem_q, low_q[Q_W-1]};
	// quotient does not fit 32 bits when the upper numerator part reaches den
	assign over = (DEN_W'(num[SCN_W-1:Q_W]) >= den);

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= DEN_W'(num[SCN_W-1:Q_W]);
			low_q <= num[Q_W-1:0];
			quo_q <= over ? '1 : '0;
		end else if (busy_q) begin
			low_q <= low_q << 1;
			if (rem2 >= {1'b0, den_q}) begin
				rem_q <= DEN_W'(rem2 - {1'b0, den_q});
				quo_q <= {quo_q[Q_W-2:0], 1'b1};
			end else begin
				rem_q <= rem2[DEN_W-1:0];
				quo_q <= {quo_q[Q_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !over;
				done_q <= over;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[rtl/sgtd_back.sv]
// ----------------------------------------------------------------------------
// sgtd_back
// Execution side: sample ring, window pass with three Goertzel recurrences
// and energy, power products, score and contrast divisions, result register.
// ----------------------------------------------------------------------------
module sgtd_back import sgtd_pkg::*; #(
	parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int AW   = $clog2(MAX_WINDOW),
	localparam int WL_W = $clog2(MAX_WINDOW + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  q_ctl_t                   q_ctl,
	input  logic [SAMPLE_BITS-1:0]   q_sample,
	output logic                     pop,
	input  logic [WL_W-1:0]          wl,
	input  logic [2:0][COEF_W-1:0]   coefs,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     out_window_ready,
	output logic [Q_W-1:0]           out_score,
	output logic [Q_W-1:0]           out_contrast,
	output logic [P_W-1:0]           out_power,
	output logic [P_W-1:0]           out_neighbor,
	output logic [E_W-1:0]           out_energy
);

	localparam int SQ_W = 2 * SAMPLE_BITS;
	localparam int ES_W = ((E_W > SQ_W) ? E_W : SQ_W) + 1;

	back_state_t state_q, state_d;

	logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]  valid_q;

	logic [AW-1:0]   wp_q;
	logic [WL_W-1:0] fill_q;
	logic [WL_W-1:0] mod_q;
	logic [AW-1:0]   idx_q;
	logic [WL_W-1:0] cnt_q;
	logic            phase_q;
	logic            win_ok_q;

	logic [SAMPLE_BITS-1:0] rd_s1;
	logic                   rdv_s1;

	logic signed [S_W-1:0] s1_q [3];
	logic signed [S_W-1:0] s2_q [3];
	logic signed [R_W-1:0] r_q  [3];
	logic [HI_W-1:0]       mhi_s1 [3];
	logic [LO_W-1:0]       mlo_s1 [3];
	logic                  neg_s1 [3];
	logic signed [R_W-1:0] rnd [3];

	logic [E_W-1:0]          energy_q;
	logic [1:0]              ch_q;
	logic [1:0]              term_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [P_W-1:0]          pwr_q [3];
	logic [P_W-1:0]          nb_q;
	logic [SCN_W-1:0]        scn_s1;
	logic [Q_W-1:0]          score_q;
	logic [Q_W-1:0]          contrast_q;

	logic out_valid_q;
	logic out_flag_q;
	logic [Q_W-1:0] out_score_q, out_contrast_q;
	logic [P_W-1:0] out_power_q, out_neighbor_q;
	logic [E_W-1:0] out_energy_q;

	logic push_en, rd_en, prod_en, last, load_out;
	logic mul_start, mul_done, div_start, div_done;
	logic signed [R_W-1:0]   mul_a;
	logic signed [S_W-1:0]   mul_b;
	logic signed [ACC_W-1:0] mul_prod;
	logic signed [ACC_W-1:0] acc_next;
	logic [SCN_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic [Q_W-1:0]   div_quo;
	logic signed [SAMPLE_BITS-1:0] x;
	logic [ES_W-1:0]  e_sum;

	function automatic logic signed [S_W-1:0] sat_s(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi, lo;
		begin
			hi = SUM_W'({1'b0, {(S_W-1){1'b1}}});
			lo = -hi - SUM_W'(1);
			if (v > hi) begin
				sat_s = {1'b0, {(S_W-1){1'b1}}};
			end else if (v < lo) begin
				sat_s = {1'b1, {(S_W-1){1'b0}}};
			end else begin
				sat_s = v[S_W-1:0];
			end
		end
	endfunction

	function automatic logic [P_W-1:0] sat_p(input logic signed [ACC_W-1:0] v);
		begin
			if (v < 0) begin
				sat_p = '0;
			end else if (v > $signed(ACC_W'({P_W{1'b1}}))) begin
				sat_p = '1;
			end else begin
				sat_p = v[P_W-1:0];
			end
		end
	endfunction

	// ---------------- control ----------------

	assign last = (cnt_q == wl - WL_W'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (q_ctl.valid) state_d = q_ctl.clear ? ST_OUT : ST_MOD;
			ST_MOD:       if (mod_q < wl) state_d = (fill_q < wl) ? ST_OUT : ST_RUN;
			ST_RUN:       if (phase_q && last) state_d = ST_FIN;
			ST_FIN:       state_d = ST_FIN2;
			ST_FIN2:      state_d = ST_PWR_GO;
			ST_PWR_GO:    state_d = ST_PWR_WAIT;
			ST_PWR_WAIT: begin
				if (mul_done) begin
					state_d = (term_q == TERM_CROSS && ch_q == 2'd2) ? ST_SMUL : ST_PWR_GO;
				end
			end
			ST_SMUL:      state_d = ST_SDIV_GO;
			ST_SDIV_GO:   state_d = ST_SDIV_WAIT;
			ST_SDIV_WAIT: if (div_done) state_d = ST_CDIV_GO;
			ST_CDIV_GO:   state_d = ST_CDIV_WAIT;
			ST_CDIV_WAIT: if (div_done) state_d = ST_OUT;
			ST_OUT:       if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop       = (state_q == ST_IDLE) && q_ctl.valid;
		push_en   = pop && !q_ctl.clear;
		rd_en     = (state_q == ST_RUN) && !phase_q;
		prod_en   = rd_en || (state_q == ST_FIN);
		mul_start = (state_q == ST_PWR_GO);
		div_start = (state_q == ST_SDIV_GO) || (state_q == ST_CDIV_GO);
		load_out  = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- sample ring ----------------

	always_ff @(posedge clk) begin
		if (push_en) begin
			ring[wp_q] <= q_sample;
		end
		if (rd_en) begin
			rd_s1 <= ring[idx_q];
		end
	end

	// entries not written since the last clear read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rdv_s1  <= 1'b0;
		end else begin
			if (pop && q_ctl.clear) begin
				valid_q <= '0;
			end else if (push_en) begin
				valid_q[wp_q] <= 1'b1;
			end
			if (rd_en) begin
				rdv_s1 <= valid_q[idx_q];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			fill_q   <= '0;
			mod_q    <= '0;
			idx_q    <= '0;
			cnt_q    <= '0;
			phase_q  <= 1'b0;
			win_ok_q <= 1'b0;
			ch_q     <= '0;
			term_q   <= TERM_S1SQ;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					win_ok_q <= 1'b0;
					if (pop && q_ctl.clear) begin
						wp_q   <= '0;
						fill_q <= '0;
					end else if (pop) begin
						mod_q <= WL_W'(wp_q) + WL_W'(1);
						if (fill_q < wl) begin
							fill_q <= fill_q + WL_W'(1);
						end
					end
				end
				ST_MOD: begin
					// write position reduced by the window length, one subtract a cycle
					if (mod_q >= wl) begin
						mod_q <= mod_q - wl;
					end else begin
						wp_q     <= mod_q[AW-1:0];
						idx_q    <= mod_q[AW-1:0];
						cnt_q    <= '0;
						phase_q  <= 1'b0;
						win_ok_q <= !(fill_q < wl);
					end
				end
				ST_RUN: begin
					phase_q <= ~phase_q;
					if (phase_q) begin
						cnt_q <= cnt_q + WL_W'(1);
						idx_q <= (WL_W'(idx_q) + WL_W'(1) == wl) ? '0 : idx_q + AW'(1);
					end
				end
				ST_PWR_WAIT: begin
					if (mul_done) begin
						if (term_q == TERM_CROSS) begin
							term_q <= TERM_S1SQ;
							ch_q   <= ch_q + 2'd1;
						end else begin
							term_q <= term_q + 2'd1;
						end
					end
				end
				ST_SMUL: begin
					ch_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// ---------------- window pass datapath ----------------

	assign x = rdv_s1 ? $signed(rd_s1) : '0;
	assign e_sum = ES_W'(energy_q) + ES_W'($unsigned(SQ_W'(x) * SQ_W'(x)));

	for (genvar c = 0; c < 3; c++) begin : g_ch
		logic [CMAG_W-1:0]   mc;
		logic [S_W-1:0]      mv;
		logic [LO_W:0]       lo_rnd;
		logic [M_W-1:0]      m;
		logic signed [SUM_W-1:0] s_new;

		assign mc = coefs[c][COEF_W-1] ? CMAG_W'(-$signed(coefs[c])) : CMAG_W'(coefs[c]);
		assign mv = s1_q[c][S_W-1] ? S_W'(-s1_q[c]) : S_W'(s1_q[c]);
		// c*s1/2^16, rounded half away from zero on the magnitude
		assign lo_rnd = (LO_W+1)'(mlo_s1[c]) + ROUND_HALF;
		assign m      = M_W'(mhi_s1[c]) + M_W'(lo_rnd[LO_W:FRAC_W]);
		assign rnd[c] = neg_s1[c] ? -$signed({1'b0, m}) : $signed({1'b0, m});
		assign s_new  = SUM_W'(x) + SUM_W'(rnd[c]) - SUM_W'(s2_q[c]);

		always_ff @(posedge clk) begin
			if (prod_en) begin
				mhi_s1[c] <= mv[S_W-1:FRAC_W] * mc;
				mlo_s1[c] <= mv[FRAC_W-1:0] * mc;
				neg_s1[c] <= coefs[c][COEF_W-1] ^ s1_q[c][S_W-1];
			end
			if (state_q == ST_MOD) begin
				s1_q[c] <= '0;
				s2_q[c] <= '0;
			end else if (state_q == ST_RUN && phase_q) begin
				s2_q[c] <= s1_q[c];
				s1_q[c] <= sat_s(s_new);
			end
			if (state_q == ST_FIN2) begin
				r_q[c] <= rnd[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MOD) begin
			energy_q <= '0;
		end else if (state_q == ST_RUN && phase_q) begin
			energy_q <= (e_sum > ES_W'({E_W{1'b1}})) ? '1 : e_sum[E_W-1:0];
		end
	end

	// ---------------- power products ----------------

	always_comb begin
		case (term_q)
			TERM_S1SQ: begin
				mul_a = R_W'(s1_q[ch_q]);
				mul_b = s1_q[ch_q];
			end
			TERM_S2SQ: begin
				mul_a = R_W'(s2_q[ch_q]);
				mul_b = s2_q[ch_q];
			end
			default: begin
				mul_a = r_q[ch_q];
				mul_b = s2_q[ch_q];
			end
		endcase
	end

	assign acc_next = (term_q == TERM_CROSS) ? acc_q - mul_prod : acc_q + mul_prod;

	sgtd_wmul u_wmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN2) begin
			acc_q <= '0;
		end else if (state_q == ST_PWR_WAIT && mul_done) begin
			if (term_q == TERM_CROSS) begin
				pwr_q[ch_q] <= sat_p(acc_next);
				acc_q       <= '0;
			end else begin
				acc_q <= acc_next;
			end
		end
		if (state_q == ST_SMUL) begin
			scn_s1 <= pwr_q[0] * SCORE_K;
			nb_q   <= P_W'((DEN_W'(pwr_q[1]) + DEN_W'(pwr_q[2])) >> 1);
		end
		if (state_q == ST_SDIV_WAIT && div_done) begin
			score_q <= div_quo;
		end
		if (state_q == ST_CDIV_WAIT && div_done) begin
			contrast_q <= div_quo;
		end
	end

	// ---------------- score and contrast ----------------

	always_comb begin
		if (state_q == ST_SDIV_GO) begin
			div_num = scn_s1;
			div_den = DEN_W'(energy_q) + DEN_W'(1);
		end else begin
			div_num = SCN_W'({pwr_q[0], 8'd0});
			div_den = DEN_W'(nb_q) + DEN_W'(1);
		end
	end

	sgtd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// ---------------- result register ----------------

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_flag_q     <= win_ok_q;
			out_score_q    <= win_ok_q ? score_q    : '0;
			out_contrast_q <= win_ok_q ? contrast_q : '0;
			out_power_q    <= win_ok_q ? pwr_q[0]   : '0;
			out_neighbor_q <= win_ok_q ? nb_q       : '0;
			out_energy_q   <= win_ok_q ? energy_q   : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_window_ready = out_flag_q;
	assign out_score        = out_score_q;
	assign out_contrast     = out_contrast_q;
	assign out_power        = out_power_q;
	assign out_neighbor     = out_neighbor_q;
	assign out_energy       = out_energy_q;

`ifndef SYNTHESIS
	a_idx_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> WL_W'(idx_q) < wl)
		else $error("ring index outside window");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == ST_IDLE)
		else $error("queue popped while busy");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && !out_valid_q |=> out_valid_q)
		else $error("result not loaded");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> fill_q >= wl)
		else $error("pass started on a partial window");
`endif

endmodule
